FILE: src/crpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crpp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] addr_t;
  typedef logic [2:0] kind_t;
  typedef logic [1:0] phase_t;

  localparam phase_t PH_HEADER = 2'd0;
  localparam phase_t PH_KIND   = 2'd1;
  localparam phase_t PH_BODY   = 2'd2;

  localparam byte_t  TERM_BYTE = 8'hFF;
  localparam logic [3:0] KIND_MIN = 4'd3;
  localparam logic [3:0] KIND_MAX = 4'd6;

endpackage

`default_nettype wire

FILE: src/camera_reply_packet_parser.sv
// Frames camera-control reply packets from a serial byte stream, one received
// byte per request. Header, kind and payload bytes are taken while no drain
// runs, and payload bytes go into a single-port store of MAX_PAYLOAD bytes.
// The 0xFF terminator starts a drain: each buffered byte takes a store read
// with registered data, then a load into the output register, which waits
// while the output is stalled; the input is held until the packet's last
// result, or the single result of an empty packet, is loaded. Input is
// stalled only during a drain; a finished result may wait in the output
// register while new bytes are taken. Payload beyond MAX_PAYLOAD bytes is
// dropped and the packet's results carry truncated set.
`timescale 1ns / 1ps
`default_nettype none

module camera_reply_packet_parser #(
  parameter int MAX_PAYLOAD = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  crpp_pkg::byte_t in_rx_byte,
  output logic                  out_valid,
  input  wire                   out_stall,
  output crpp_pkg::addr_t       out_sender_address,
  output crpp_pkg::kind_t       out_reply_kind,
  output crpp_pkg::byte_t       out_payload_byte,
  output logic                  out_has_payload,
  output logic                  out_last_of_packet,
  output logic                  out_truncated
);

  import crpp_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_EMPTY = 2'd3;

  logic [1:0]    state_r, state_nxt;
  phase_t        phase_r, phase_nxt;
  addr_t         sender_r, sender_nxt;
  kind_t         kind_r, kind_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  byte_t         mem [MAX_PAYLOAD];
  byte_t         rd_data_r;

  addr_t         out_sender_r;
  kind_t         out_kind_r;
  byte_t         out_byte_r;
  logic          out_has_r;
  logic          out_last_r;
  logic          out_trunc_r;

  logic          in_acc;
  logic          slot_free;
  logic          load_data;
  logic          load_empty;
  logic          mem_we;
  logic          is_last;
  logic [3:0]    kind_nib;
  logic          hdr_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign load_data  = (state_r == S_LOAD) && slot_free;
  assign load_empty = (state_r == S_EMPTY) && slot_free;
  assign is_last   = ({1'b0, rd_idx_r} + (CW+1)'(1)) == {1'b0, count_r};
  assign kind_nib  = in_rx_byte[7:4];
  assign hdr_ok    = in_rx_byte[7] && (in_rx_byte[2:0] == 3'd0) &&
                     (in_rx_byte[3] ? (in_rx_byte[6:4] == 3'd0)
                                    : (in_rx_byte[6:4] != 3'd0));
  assign mem_we    = in_acc && (phase_r == PH_BODY) && (in_rx_byte != TERM_BYTE) &&
                     (count_r < CNT_MAX);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    sender_nxt    = sender_r;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (phase_r)
            PH_KIND: begin
              if (kind_nib >= KIND_MIN && kind_nib <= KIND_MAX) begin
                kind_nxt  = kind_nib[2:0];
                phase_nxt = PH_BODY;
              end else begin
                phase_nxt  = PH_HEADER;
                sender_nxt = '0;
                kind_nxt   = '0;
                count_nxt  = '0;
                ovf_nxt    = 1'b0;
              end
            end
            PH_BODY: begin
              if (in_rx_byte != TERM_BYTE) begin
                if (count_r < CNT_MAX) begin
                  count_nxt = count_r + CW'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end else begin
                phase_nxt  = PH_HEADER;
                rd_idx_nxt = '0;
                state_nxt  = (count_r == '0) ? S_EMPTY : S_READ;
              end
            end
            default: begin
              phase_nxt = PH_HEADER;
              if (hdr_ok) begin
                sender_nxt = in_rx_byte[6:4];
                phase_nxt  = PH_KIND;
              end
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (is_last) begin
            state_nxt  = S_IDLE;
            sender_nxt = '0;
            kind_nxt   = '0;
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + CW'(1);
            state_nxt  = S_READ;
          end
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          sender_nxt    = '0;
          kind_nxt      = '0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HEADER;
      sender_r    <= '0;
      kind_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      sender_r    <= sender_nxt;
      kind_r      <= kind_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= in_rx_byte;
    end
    if (state_r == S_READ) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_data || load_empty) begin
      out_sender_r <= sender_r;
      out_kind_r   <= kind_r;
      out_byte_r   <= load_data ? rd_data_r : 8'd0;
      out_has_r    <= load_data;
      out_last_r   <= load_empty || is_last;
      out_trunc_r  <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sender_address = out_sender_r;
  assign out_reply_kind     = out_kind_r;
  assign out_payload_byte   = out_byte_r;
  assign out_has_payload    = out_has_r;
  assign out_last_of_packet = out_last_r;
  assign out_truncated      = out_trunc_r;

endmodule

`default_nettype wire
